// ===== hw/rtl/lpt_pkg.sv =====
// ----------------------------------------------------------------------------
// lpt_pkg
// Shared constants and types for the LRU page table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpt_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int PAGE_BITS_DEF  = 20;
  localparam int FRAME_BITS_DEF = 16;

  // capacity register and resident count fields are fixed at five bits
  localparam int CAP_W   = 5;
  localparam int COUNT_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    ST_IDLE,
    ST_LOOK
  } state_t;

  // per-cycle control broadcast to every cell of the row
  typedef struct packed {
    logic update;  // table changes at this edge
    logic miss;    // no cell matched the key
  } cell_ctl_t;

endpackage

// ===== hw/rtl/lpt_if.sv =====
// ----------------------------------------------------------------------------
// lpt_if
// Valid/ready channels of the LRU page table: request, response, config.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lpt_req_if #(
  parameter int PAGE_BITS  = lpt_pkg::PAGE_BITS_DEF,
  parameter int FRAME_BITS = lpt_pkg::FRAME_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [PAGE_BITS-1:0]  vpn;
  logic [FRAME_BITS-1:0] install_frame;

  modport source (output valid, vpn, install_frame, input ready);
  modport sink   (input valid, vpn, install_frame, output ready);
endinterface

interface lpt_rsp_if #(
  parameter int FRAME_BITS = lpt_pkg::FRAME_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic [FRAME_BITS-1:0]       pfn;
  logic                        evicted;
  logic [lpt_pkg::COUNT_W-1:0] resident_count;

  modport source (output valid, hit, pfn, evicted, resident_count, input ready);
  modport sink   (input valid, hit, pfn, evicted, resident_count, output ready);
endinterface

interface lpt_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [lpt_pkg::CAP_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== hw/rtl/lpt_cell.sv =====
// ----------------------------------------------------------------------------
// lpt_cell
// One entry of the recency-ordered row: holds a page/frame pair, compares
// against the key and takes its upstream neighbor's entry when it shifts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpt_cell #(
  parameter int PAGE_BITS  = lpt_pkg::PAGE_BITS_DEF,
  parameter int FRAME_BITS = lpt_pkg::FRAME_BITS_DEF,
  parameter int CNT_W      = 5,
  parameter int INDEX      = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  lpt_pkg::cell_ctl_t     ctl,
  input  logic [CNT_W-1:0]       cap,
  input  logic [PAGE_BITS-1:0]   key,
  input  logic                   prev_valid,
  input  logic [PAGE_BITS-1:0]   prev_page,
  input  logic [FRAME_BITS-1:0]  prev_frame,
  input  logic                   below_match,
  output logic                   valid,
  output logic [PAGE_BITS-1:0]   page,
  output logic [FRAME_BITS-1:0]  frame,
  output logic                   match,
  output logic                   chain_match
);

  logic shift;
  logic keep;

  always_comb begin
    match       = valid && (page == key);
    // set when this cell or any older one holds the key
    chain_match = match | below_match;
    // a hit rotates the head down to the hit cell; a miss shifts the whole row
    shift       = ctl.update && (ctl.miss || chain_match);
    // on a miss, cells at rank capacity and beyond fall off the end
    keep        = !ctl.miss || (CNT_W'(INDEX) < cap);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= prev_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      page  <= prev_page;
      frame <= prev_frame;
    end
  end

endmodule

// ===== hw/rtl/lru_page_table.sv =====
// ----------------------------------------------------------------------------
// lru_page_table
// Fully associative page table in least-recently-used order, built as a row
// of cells sorted by recency with the most recent entry at the head. Each
// request beat is registered at the edge that accepts it; every cell then
// compares its page against the key in parallel, and once the response
// register can take the result a hit rotates the head of the row down to the
// hit cell and a miss shifts the whole row by one and writes the new page at
// the head, dropping anything at or beyond the capacity. The result register
// lets the next request beat be accepted while a response still waits.
// Capacity is clamped to 1..ENTRIES; lowering it takes effect at the next
// miss. Reset empties the table at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_page_table #(
  parameter int ENTRIES    = lpt_pkg::ENTRIES_DEF,
  parameter int PAGE_BITS  = lpt_pkg::PAGE_BITS_DEF,
  parameter int FRAME_BITS = lpt_pkg::FRAME_BITS_DEF
) (
  input logic     clk,
  input logic     rst,
  lpt_req_if.sink req,
  lpt_rsp_if.source rsp,
  lpt_cfg_if.sink cfg
);

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > lpt_pkg::CAP_W) ? CNT_W : lpt_pkg::CAP_W;

  lpt_pkg::state_t state, state_next;

  logic [lpt_pkg::CAP_W-1:0] capacity;
  logic [CMP_W-1:0]          cap_ext;
  logic [CNT_W-1:0]          eff_cap;
  logic [CNT_W-1:0]          occupancy, occupancy_next;

  logic [PAGE_BITS-1:0]      page_q;
  logic [FRAME_BITS-1:0]     frame_q;

  logic                      rsp_valid;
  logic                      rsp_hit;
  logic [FRAME_BITS-1:0]     rsp_frame;
  logic                      rsp_evicted;
  logic [CNT_W-1:0]          rsp_count;

  logic                      load_out;
  logic                      hit;
  logic                      evict;
  logic [FRAME_BITS-1:0]     sel_frame;
  logic [FRAME_BITS-1:0]     head_frame;
  lpt_pkg::cell_ctl_t        ctl;

  logic                      cell_valid [ENTRIES];
  logic [PAGE_BITS-1:0]      cell_page  [ENTRIES];
  logic [FRAME_BITS-1:0]     cell_frame [ENTRIES];
  logic                      cell_match [ENTRIES];
  logic                      cell_chain [ENTRIES+1];
  logic [ENTRIES-1:0]        valid_vec;
  logic [ENTRIES-1:0]        match_vec;

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lpt_pkg::CAP_RESET;
    end else if (cfg.valid && cfg.ready) begin
      capacity <= cfg.data;
    end
  end

  always_comb begin
    cap_ext = CMP_W'(capacity);
    if (cap_ext == '0) begin
      eff_cap = CNT_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      eff_cap = CNT_W'(ENTRIES);
    end else begin
      eff_cap = CNT_W'(cap_ext);
    end
  end

  // request register
  assign req.ready = (state == lpt_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      page_q  <= req.vpn;
      frame_q <= req.install_frame;
    end
  end

  // cell row
  assign cell_chain[ENTRIES] = 1'b0;

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      if (g == 0) begin : g_head
        lpt_cell #(
          .PAGE_BITS  (PAGE_BITS),
          .FRAME_BITS (FRAME_BITS),
          .CNT_W      (CNT_W),
          .INDEX      (g)
        ) u_cell (
          .clk         (clk),
          .rst         (rst),
          .ctl         (ctl),
          .cap         (eff_cap),
          .key         (page_q),
          .prev_valid  (1'b1),
          .prev_page   (page_q),
          .prev_frame  (head_frame),
          .below_match (cell_chain[g+1]),
          .valid       (cell_valid[g]),
          .page        (cell_page[g]),
          .frame       (cell_frame[g]),
          .match       (cell_match[g]),
          .chain_match (cell_chain[g])
        );
      end else begin : g_body
        lpt_cell #(
          .PAGE_BITS  (PAGE_BITS),
          .FRAME_BITS (FRAME_BITS),
          .CNT_W      (CNT_W),
          .INDEX      (g)
        ) u_cell (
          .clk         (clk),
          .rst         (rst),
          .ctl         (ctl),
          .cap         (eff_cap),
          .key         (page_q),
          .prev_valid  (cell_valid[g-1]),
          .prev_page   (cell_page[g-1]),
          .prev_frame  (cell_frame[g-1]),
          .below_match (cell_chain[g+1]),
          .valid       (cell_valid[g]),
          .page        (cell_page[g]),
          .frame       (cell_frame[g]),
          .match       (cell_match[g]),
          .chain_match (cell_chain[g])
        );
      end
      assign valid_vec[g] = cell_valid[g];
      assign match_vec[g] = cell_match[g];
    end
  endgenerate

  // pages are unique among valid cells, so at most one match drives the mux
  always_comb begin
    sel_frame = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      sel_frame = sel_frame | (cell_frame[i] & {FRAME_BITS{cell_match[i]}});
    end
  end

  always_comb begin
    hit        = cell_chain[0];
    head_frame = hit ? sel_frame : frame_q;
    load_out   = (state == lpt_pkg::ST_LOOK) && (!rsp_valid || rsp.ready);
    ctl.update = load_out;
    ctl.miss   = !hit;
    evict      = 1'b0;
    occupancy_next = occupancy;
    if (!hit) begin
      if (occupancy >= eff_cap) begin
        evict          = 1'b1;
        occupancy_next = eff_cap;
      end else begin
        occupancy_next = occupancy + CNT_W'(1);
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lpt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      lpt_pkg::ST_IDLE: begin
        if (req.valid && req.ready) begin
          state_next = lpt_pkg::ST_LOOK;
        end
      end
      lpt_pkg::ST_LOOK: begin
        if (load_out) begin
          state_next = lpt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lpt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (load_out) begin
        occupancy <= occupancy_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp_hit     <= hit;
      rsp_frame   <= head_frame;
      rsp_evicted <= evict;
      rsp_count   <= occupancy_next;
    end
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.hit            = rsp_hit;
  assign rsp.pfn            = rsp_frame;
  assign rsp.evicted        = rsp_evicted;
  assign rsp.resident_count = lpt_pkg::COUNT_W'(rsp_count);

  // checks
  a_count_matches_cells: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(occupancy))
    else $error("resident count differs from number of valid cells");

  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    (valid_vec[ENTRIES-1:1] & ~valid_vec[ENTRIES-2:0]) == '0)
    else $error("valid cells are not packed at the head of the row");

  a_single_match: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match_vec))
    else $error("page resident in more than one cell");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    load_out && hit |=> !rsp_evicted && (rsp_count == $past(occupancy)))
    else $error("hit changed the resident count");

endmodule

// ===== bench/lru_page_table_tb.sv =====
// ----------------------------------------------------------------------------
// lru_page_table_tb
// Self-checking bench for the LRU page table. A scripted opening walks the
// corner cases (empty table, all-zero and all-one pages, capacity clamps,
// lowering capacity under a full table), then randomized phases hit the
// table at several capacities. A behavioral model of the recency order
// predicts the beats the script leaves open; each is checked field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_page_table_tb;

  localparam int ENTRIES     = lpt_pkg::ENTRIES_DEF;
  localparam int PAGE_BITS   = lpt_pkg::PAGE_BITS_DEF;
  localparam int FRAME_BITS  = lpt_pkg::FRAME_BITS_DEF;
  localparam int CAP_W       = lpt_pkg::CAP_W;
  localparam int COUNT_W     = lpt_pkg::COUNT_W;
  localparam int IDLE_PCT    = 23;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 115;
  localparam int POOL_SIZE   = 40;

  typedef logic [PAGE_BITS-1:0]  page_t;
  typedef logic [FRAME_BITS-1:0] frame_t;

  typedef struct packed {
    logic               hit;
    frame_t             frame;
    logic               evicted;
    logic [COUNT_W-1:0] count;
  } access_result_t;

  typedef enum logic {
    ROW_ACCESS,
    ROW_CONFIG
  } row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [CAP_W-1:0] cap;
    page_t            page;
    frame_t           frame;
    logic             typed;
    access_result_t   want;
  } script_row_t;

  logic clk;
  logic rst;

  lpt_req_if req ();
  lpt_rsp_if rsp ();
  lpt_cfg_if cfg ();

  lru_page_table uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  // model of the table
  logic             slot_live  [ENTRIES];
  page_t            slot_page  [ENTRIES];
  frame_t           slot_frame [ENTRIES];
  int unsigned      slot_age   [ENTRIES];
  int unsigned      live_count;
  logic [CAP_W-1:0] capacity_reg;

  access_result_t pending_results [$];
  script_row_t    script [$];
  int unsigned    phase_caps [$];
  page_t          pool [POOL_SIZE];

  int  mismatches = 0;
  int  n_hits;
  int  n_misses;
  int  n_evictions;
  int  n_cap_writes;
  int  idle_cycles = 0;
  int  hold_left = 0;
  int  holds_asked;
  int  holds_done = 0;
  bit  calm;
  bit  bad;
  access_result_t want;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int unsigned clamp_capacity(input logic [CAP_W-1:0] c);
    if (c == 0) return 1;
    if (c > ENTRIES) return ENTRIES;
    return int'(c);
  endfunction

  // look up one page, update recency order, return the response beat
  function automatic access_result_t lookup_and_touch(input page_t p, input frame_t f);
    access_result_t r;
    int found;
    int slot;
    int unsigned cnt;
    int unsigned cap;
    int unsigned age;
    r = '0;
    found = -1;
    slot = -1;
    cnt = 0;
    for (int i = 0; i < ENTRIES; i++)
      if (found < 0 && slot_live[i] && slot_page[i] == p) found = i;
    if (found >= 0) begin
      age = slot_age[found];
      for (int i = 0; i < ENTRIES; i++)
        if (slot_live[i] && slot_age[i] < age) slot_age[i]++;
      slot_age[found] = 0;
      r.hit = 1'b1;
      r.frame = slot_frame[found];
    end else begin
      cap = clamp_capacity(capacity_reg);
      // a lowered capacity drops every entry past the new limit at once
      for (int i = 0; i < ENTRIES; i++)
        if (slot_live[i] && slot_age[i] >= cap - 1) begin
          slot_live[i] = 1'b0;
          r.evicted = 1'b1;
        end
      for (int i = 0; i < ENTRIES; i++)
        if (slot_live[i]) begin
          slot_age[i]++;
          cnt++;
        end else if (slot < 0) begin
          slot = i;
        end
      if (slot >= 0) begin
        slot_live[slot] = 1'b1;
        slot_page[slot] = p;
        slot_frame[slot] = f;
        slot_age[slot] = 0;
        cnt++;
      end
      live_count = cnt;
      r.frame = f;
    end
    r.count = live_count[COUNT_W-1:0];
    return r;
  endfunction

  function automatic script_row_t mk_row(input row_kind_e kind, input logic [CAP_W-1:0] cap,
                                         input page_t p, input frame_t f, input logic typed,
                                         input logic hit, input frame_t frm,
                                         input logic ev, input logic [COUNT_W-1:0] cnt);
    script_row_t r;
    r.kind = kind;
    r.cap = cap;
    r.page = p;
    r.frame = f;
    r.typed = typed;
    r.want.hit = hit;
    r.want.frame = frm;
    r.want.evicted = ev;
    r.want.count = cnt;
    return r;
  endfunction

  task automatic put_access(input page_t p, input frame_t f, input logic typed,
                            input access_result_t typed_want);
    access_result_t pred;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.vpn <= p;
    req.install_frame <= f;
    do @(posedge clk); while (!req.ready);
    pred = lookup_and_touch(p, f);
    pending_results.push_back(typed ? typed_want : pred);
    if (pred.hit) n_hits++;
    else n_misses++;
    if (pred.evicted) n_evictions++;
  endtask

  task automatic drain_results();
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    drain_results();
    repeat (3) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.data <= v;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    capacity_reg = v;
    n_cap_writes++;
  endtask

  // response side: random backpressure plus requested long hold-offs
  always @(posedge clk) begin
    if (hold_left != 0) begin
      rsp.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_asked != holds_done) begin
      rsp.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end else if (calm) begin
      rsp.ready <= 1'b1;
    end else begin
      rsp.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // response checker
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected response beat: hit=%0b frame=%h evicted=%0b count=%0d",
                   $realtime, rsp.hit, rsp.pfn, rsp.evicted, rsp.resident_count);
      end else begin
        want = pending_results.pop_front();
        bad = (rsp.hit !== want.hit) || (rsp.pfn !== want.frame) ||
              (rsp.evicted !== want.evicted) || (rsp.resident_count !== want.count);
        if (bad) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"[%0t] response mismatch: expected hit=%0b frame=%h evicted=%0b ",
                      "count=%0d, got hit=%0b frame=%h evicted=%0b count=%0d"},
                     $realtime, want.hit, want.frame, want.evicted, want.count,
                     rsp.hit, rsp.pfn, rsp.evicted, rsp.resident_count);
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no beat for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned ws;
    int unsigned cap;
    access_result_t none;
    page_t p;

    rst = 1'b1;
    req.valid = 1'b0;
    req.vpn = '0;
    req.install_frame = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    n_hits = 0;
    n_misses = 0;
    n_evictions = 0;
    n_cap_writes = 0;
    holds_asked = 0;
    calm = 1'b0;
    none = '0;
    capacity_reg = lpt_pkg::CAP_RESET;
    live_count = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      slot_live[i] = 1'b0;
      slot_page[i] = '0;
      slot_frame[i] = '0;
      slot_age[i] = 0;
    end

    // opening script: empty table, extremes, clamps, capacity cut under load
    script.push_back(mk_row(ROW_ACCESS, 0, 20'h00000, 16'h0000, 1, 0, 16'h0000, 0, 1));
    script.push_back(mk_row(ROW_ACCESS, 0, 20'hFFFFF, 16'hFFFF, 1, 0, 16'hFFFF, 0, 2));
    script.push_back(mk_row(ROW_ACCESS, 0, 20'h00000, 16'h1234, 1, 1, 16'h0000, 0, 2));
    script.push_back(mk_row(ROW_ACCESS, 0, 20'hFFFFF, 16'h0000, 1, 1, 16'hFFFF, 0, 2));
    script.push_back(mk_row(ROW_CONFIG, 2, '0, '0, 0, 0, '0, 0, 0));
    script.push_back(mk_row(ROW_ACCESS, 0, 20'h12345, 16'hAAAA, 1, 0, 16'hAAAA, 1, 2));
    script.push_back(mk_row(ROW_ACCESS, 0, 20'h00000, 16'h5555, 1, 0, 16'h5555, 1, 2));
    script.push_back(mk_row(ROW_CONFIG, 0, '0, '0, 0, 0, '0, 0, 0));
    script.push_back(mk_row(ROW_ACCESS, 0, 20'h00000, 16'h0001, 1, 1, 16'h5555, 0, 2));
    script.push_back(mk_row(ROW_ACCESS, 0, 20'h54321, 16'h0F0F, 1, 0, 16'h0F0F, 1, 1));
    script.push_back(mk_row(ROW_ACCESS, 0, 20'h54321, 16'hFFFF, 1, 1, 16'h0F0F, 0, 1));
    script.push_back(mk_row(ROW_ACCESS, 0, 20'hABCDE, 16'hF0F0, 1, 0, 16'hF0F0, 1, 1));
    script.push_back(mk_row(ROW_CONFIG, 31, '0, '0, 0, 0, '0, 0, 0));
    script.push_back(mk_row(ROW_ACCESS, 0, 20'h0000F, 16'h00FF, 0, 0, '0, 0, 0));
    script.push_back(mk_row(ROW_ACCESS, 0, 20'h000F0, 16'hFF00, 0, 0, '0, 0, 0));
    script.push_back(mk_row(ROW_ACCESS, 0, 20'h00F00, 16'h3C3C, 0, 0, '0, 0, 0));
    script.push_back(mk_row(ROW_ACCESS, 0, 20'h0F000, 16'hC3C3, 0, 0, '0, 0, 0));
    script.push_back(mk_row(ROW_ACCESS, 0, 20'h0F000, 16'h7777, 0, 0, '0, 0, 0));
    script.push_back(mk_row(ROW_ACCESS, 0, 20'hABCDE, 16'h8888, 0, 0, '0, 0, 0));
    script.push_back(mk_row(ROW_CONFIG, 3, '0, '0, 0, 0, '0, 0, 0));
    script.push_back(mk_row(ROW_ACCESS, 0, 20'h000F0, 16'h9999, 0, 0, '0, 0, 0));
    script.push_back(mk_row(ROW_ACCESS, 0, 20'h77777, 16'h1111, 1, 0, 16'h1111, 1, 3));
    script.push_back(mk_row(ROW_CONFIG, 16, '0, '0, 0, 0, '0, 0, 0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].kind == ROW_CONFIG) write_capacity(script[i].cap);
      else put_access(script[i].page, script[i].frame, script[i].typed, script[i].want);
    end

    // random phases; the first cut from 16 to 4 lands on a full table
    phase_caps = '{16, 4, 1, 31, 0, 8, 2, 16, 15, 5, 12};
    phase_caps.push_back($urandom_range(0, 31));
    for (int i = 0; i < POOL_SIZE; i++) pool[i] = page_t'($urandom);

    foreach (phase_caps[ph]) begin
      write_capacity(phase_caps[ph][CAP_W-1:0]);
      cap = clamp_capacity(phase_caps[ph][CAP_W-1:0]);
      calm = (ph == 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        ws = cap + $urandom_range(0, 3);
        if (ws > POOL_SIZE) ws = POOL_SIZE;
        if ($urandom_range(0, 99) < 3) pool[$urandom_range(0, POOL_SIZE - 1)] = page_t'($urandom);
        if ($urandom_range(0, 99) < 85) p = pool[$urandom_range(0, ws - 1)];
        else p = page_t'($urandom);
        put_access(p, frame_t'($urandom), 1'b0, none);
        // long response hold-off so the block backs up into the request side
        if (ph == 3 && n == 40) holds_asked++;
        // sender pause until the pipeline is empty
        if (ph == 5 && n == 60) drain_results();
      end
    end
    calm = 1'b0;

    drain_results();
    repeat (20) @(posedge clk);

    $display("Ran %0d lookups: %0d hits, %0d misses, %0d with eviction.",
             n_hits + n_misses, n_hits, n_misses, n_evictions);
    $display("Capacity written %0d times, including the clamped values 0 and 31.",
             n_cap_writes);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (pending_results.size() != 0)
        $display("%0d expected responses never arrived", pending_results.size());
      $display("%0d mismatches", mismatches);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
